>>> sv/csp_pkg.sv
// shared types, codes and keyword tables for the cue settings parser
`default_nettype none

package csp_pkg;

	localparam int KW_COUNT = 5;

	localparam logic [3:0] KW_VERTICAL    = 4'd0;
	localparam logic [3:0] KW_VERTICAL_LR = 4'd1;
	localparam logic [3:0] KW_START       = 4'd2;
	localparam logic [3:0] KW_MIDDLE      = 4'd3;
	localparam logic [3:0] KW_END         = 4'd4;

	localparam logic [KW_COUNT-1:0] KW_DIR_SET   = 5'b00011;
	localparam logic [KW_COUNT-1:0] KW_ALIGN_SET = 5'b11100;

	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_D       = 8'h44;
	localparam logic [7:0] CH_A       = 8'h41;
	localparam logic [7:0] CH_L       = 8'h4C;
	localparam logic [7:0] CH_T       = 8'h54;
	localparam logic [7:0] CH_S       = 8'h53;

	localparam logic [6:0] PCT_MAX  = 7'd100;
	localparam logic [6:0] PCT_CLIP = 7'd101;

	localparam logic [1:0] DIR_HORIZONTAL = 2'd0;
	localparam logic [1:0] ALIGN_MIDDLE   = 2'd1;

	typedef enum logic [6:0] {
		PH_SKIP    = 7'b0000001,
		PH_SEP     = 7'b0000010,
		PH_WORD    = 7'b0000100,
		PH_LNUM    = 7'b0001000,
		PH_DIGITS  = 7'b0010000,
		PH_PCT     = 7'b0100000,
		PH_DISCARD = 7'b1000000
	} phase_t;

	typedef enum logic [2:0] {
		K_NONE  = 3'd0,
		K_DIR   = 3'd1,
		K_ALIGN = 3'd2,
		K_LINE  = 3'd3,
		K_TEXT  = 3'd4,
		K_SIZE  = 3'd5
	} kind_t;

	typedef struct packed {
		logic started;
		logic neg;
		logic digit;
		logic pct;
		logic bad;
		logic ovf;
	} vflags_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       no_char;
		logic       string_end;
	} item_t;

	typedef struct packed {
		logic [1:0]        writing_dir;
		logic signed [31:0] line_pos;
		logic              snap_lines;
		logic [6:0]        text_pos;
		logic [6:0]        box_size;
		logic [1:0]        align_mode;
	} result_t;

	localparam result_t RESULT_DEFAULT = '{
		writing_dir: DIR_HORIZONTAL,
		line_pos:    -32'sd1,
		snap_lines:  1'b1,
		text_pos:    7'd50,
		box_size:    7'd100,
		align_mode:  ALIGN_MIDDLE
	};

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0C || c == 8'h0D;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [3:0] kw_len(input logic [3:0] k);
		logic [3:0] len;
		unique case (k)
			KW_VERTICAL:    len = 4'd8;
			KW_VERTICAL_LR: len = 4'd11;
			KW_START:       len = 4'd5;
			KW_MIDDLE:      len = 4'd6;
			KW_END:         len = 4'd3;
			default:        len = 4'd0;
		endcase
		return len;
	endfunction

	function automatic logic [87:0] kw_text(input logic [3:0] k);
		logic [87:0] txt;
		unique case (k)
			KW_VERTICAL:    txt = 88'("vertical");
			KW_VERTICAL_LR: txt = 88'("vertical-lr");
			KW_START:       txt = 88'("start");
			KW_MIDDLE:      txt = 88'("middle");
			KW_END:         txt = 88'("end");
			default:        txt = '0;
		endcase
		return txt;
	endfunction

	// character at position idx of keyword k, zero past its end
	function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] idx);
		logic [87:0] txt;
		logic [3:0]  len;
		logic [3:0]  pos;
		logic [7:0]  ch;
		txt = kw_text(k);
		len = kw_len(k);
		pos = len - 4'd1 - idx;
		ch  = 8'h00;
		if (idx < len)
			ch = txt[{pos, 3'b000} +: 8];
		return ch;
	endfunction

endpackage

`default_nettype wire

>>> sv/csp_in_stage.sv
// input register and advance control for the cue settings parser
`default_nettype none

module csp_in_stage import csp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  char_valid,
	output logic       char_stall,
	input  wire item_t item_in,
	input  wire logic  out_free,
	output item_t      item_s1,
	output logic       fire
);

	logic valid_s1;

	// an end word waits while the result register is held
	assign fire       = valid_s1 && (!item_s1.string_end || out_free);
	assign char_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			item_s1 <= item_in;
		end
	end

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> valid_s1 && item_s1.string_end && !out_free)
		else $error("input stalled without a blocked end word");

	a_held_word_kept: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |=> valid_s1 && $stable(item_s1))
		else $error("stalled word lost from input register");

endmodule

`default_nettype wire

>>> sv/csp_parse_core.sv
// parser state and per-character next-state logic
`default_nettype none

module csp_parse_core import csp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  fire,
	input  wire item_t item_s1,
	output logic       res_valid,
	output result_t    res_data
);

	phase_t              phase_q, ph;
	kind_t               kind_q, kind;
	logic [KW_COUNT-1:0] live_q, live;
	logic [3:0]          widx_q, widx;
	logic [31:0]         acc_q, acc;
	vflags_t             flg_q, flg;
	result_t             set_q, set;

	logic [7:0]  c;
	logic        sp;
	logic [3:0]  d;
	logic [35:0] lprod;
	logic [35:0] llimit;
	logic [10:0] pprod;
	logic        word_ap;
	logic        line_ap;
	logic        pct_ap;

	assign c  = item_s1.char_code;
	assign sp = is_space(c);
	assign d  = 4'(c - CH_ZERO);

	// next-step value for the line number and its range limit
	assign lprod  = {acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, d};
	assign llimit = flg_q.neg ? 36'h080000000 : 36'h07FFFFFFF;
	assign pprod  = {1'b0, acc_q[6:0], 3'b000} + {3'b000, acc_q[6:0], 1'b0} + {7'd0, d};

	always_comb begin
		ph      = phase_q;
		kind    = kind_q;
		live    = live_q;
		widx    = widx_q;
		acc     = acc_q;
		flg     = flg_q;
		set     = set_q;
		word_ap = 1'b0;
		line_ap = 1'b0;
		pct_ap  = 1'b0;

		if (!item_s1.no_char) begin
			unique case (phase_q)
				PH_SKIP: begin
					if (!sp) begin
						priority if (c == CH_D) kind = K_DIR;
						else if (c == CH_A) kind = K_ALIGN;
						else if (c == CH_L) kind = K_LINE;
						else if (c == CH_T) kind = K_TEXT;
						else if (c == CH_S) kind = K_SIZE;
						else kind = K_NONE;
						ph = PH_SEP;
					end
				end
				PH_SEP: begin
					if (c != CH_COLON)
						kind = K_NONE;
					flg  = '0;
					acc  = '0;
					widx = '0;
					live = '0;
					unique case (kind)
						K_DIR: begin
							live = KW_DIR_SET;
							ph   = PH_WORD;
						end
						K_ALIGN: begin
							live = KW_ALIGN_SET;
							ph   = PH_WORD;
						end
						K_LINE:         ph = PH_LNUM;
						K_TEXT, K_SIZE: ph = PH_DIGITS;
						default:        ph = PH_SKIP;
					endcase
				end
				PH_WORD: begin
					if (sp) begin
						word_ap = 1'b1;
						ph      = PH_SKIP;
					end else begin
						for (int k = 0; k < KW_COUNT; k++) begin
							if (widx_q >= kw_len(4'(k)) || kw_char(4'(k), widx_q) != c)
								live[k] = 1'b0;
						end
						if (widx_q != 4'hF)
							widx = widx_q + 4'd1;
					end
				end
				PH_LNUM: begin
					if (c == CH_MINUS || c == CH_PERCENT || is_digit(c)) begin
						if (flg_q.pct)
							flg.bad = 1'b1;
						priority if (c == CH_MINUS) begin
							if (flg_q.started)
								flg.bad = 1'b1;
							else
								flg.neg = 1'b1;
						end else if (c == CH_PERCENT) begin
							flg.pct = 1'b1;
						end else begin
							flg.digit = 1'b1;
							if (!flg_q.ovf) begin
								if (lprod > llimit)
									flg.ovf = 1'b1;
								else
									acc = lprod[31:0];
							end
						end
						flg.started = 1'b1;
					end else if (sp) begin
						line_ap = 1'b1;
						ph      = PH_SKIP;
					end else begin
						ph = PH_DISCARD;
					end
				end
				PH_DIGITS: begin
					if (is_digit(c)) begin
						flg.digit = 1'b1;
						if (pprod > 11'(PCT_MAX))
							acc = 32'(PCT_CLIP);
						else
							acc = 32'(pprod);
					end else if (c == CH_PERCENT) begin
						ph = PH_PCT;
					end else begin
						ph = PH_DISCARD;
					end
				end
				PH_PCT: begin
					if (sp) begin
						pct_ap = 1'b1;
						ph     = PH_SKIP;
					end else begin
						ph = PH_DISCARD;
					end
				end
				PH_DISCARD: begin
					if (sp)
						ph = PH_SKIP;
				end
				default: ph = PH_SKIP;
			endcase
		end

		// string end closes an open keyword, line number or completed percent setting
		if (item_s1.string_end) begin
			if (ph == PH_WORD) word_ap = 1'b1;
			if (ph == PH_LNUM) line_ap = 1'b1;
			if (ph == PH_PCT)  pct_ap  = 1'b1;
		end

		if (word_ap) begin
			for (int k = 0; k < KW_COUNT; k++) begin
				if (live[k] && widx == kw_len(4'(k))) begin
					if (4'(k) == KW_VERTICAL || 4'(k) == KW_VERTICAL_LR)
						set.writing_dir = 2'(k + 1);
					else
						set.align_mode = 2'(k - 2);
				end
			end
		end

		if (line_ap && !flg.bad && !flg.ovf && flg.digit && !(flg.neg && flg.pct)) begin
			if (flg.pct) begin
				if (acc <= 32'(PCT_MAX)) begin
					set.snap_lines = 1'b0;
					set.line_pos   = acc;
				end
			end else begin
				set.line_pos = flg.neg ? (32'd0 - acc) : acc;
			end
		end

		if (pct_ap && flg.digit && acc <= 32'(PCT_MAX)) begin
			if (kind == K_TEXT)
				set.text_pos = acc[6:0];
			else if (kind == K_SIZE)
				set.box_size = acc[6:0];
		end
	end

	assign res_valid = fire && item_s1.string_end;
	assign res_data  = set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			kind_q  <= K_NONE;
			live_q  <= '0;
			widx_q  <= '0;
			acc_q   <= '0;
			flg_q   <= '0;
			set_q   <= RESULT_DEFAULT;
		end else if (fire) begin
			if (item_s1.string_end) begin
				phase_q <= PH_SKIP;
				kind_q  <= K_NONE;
				live_q  <= '0;
				widx_q  <= '0;
				acc_q   <= '0;
				flg_q   <= '0;
				set_q   <= RESULT_DEFAULT;
			end else begin
				phase_q <= ph;
				kind_q  <= kind;
				live_q  <= live;
				widx_q  <= widx;
				acc_q   <= acc;
				flg_q   <= flg;
				set_q   <= set;
			end
		end
	end

	a_end_restores: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> phase_q == PH_SKIP && set_q == RESULT_DEFAULT && flg_q == '0)
		else $error("parser not back at defaults after string end");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		set_q.text_pos <= PCT_MAX && set_q.box_size <= PCT_MAX)
		else $error("percent setting out of range");

endmodule

`default_nettype wire

>>> sv/csp_out_stage.sv
// result register for the cue settings parser
`default_nettype none

module csp_out_stage import csp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_valid,
	input  wire result_t res_data,
	output logic         out_free,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result_q
);

	logic valid_q;

	assign out_free     = !valid_q || !result_stall;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			result_q <= res_data;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free)
		else $error("result written over a held word");

endmodule

`default_nettype wire

>>> sv/cue_settings_parser.sv
// top level of the cue settings parser
// result path: the string end word is held in the input register, then its result in the result register
// throughput: one character word per cycle; an end word waits in the input register
//   only while the result register holds an untaken result
// reset: arst_n clears both handshake registers and returns the parser to the
//   default settings, ready for a new string
`default_nettype none

module cue_settings_parser import csp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        char_valid,
	output logic             char_stall,
	input  wire logic [7:0]  char_code,
	input  wire logic        no_char,
	input  wire logic        string_end,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       writing_dir,
	output logic signed [31:0] line_pos,
	output logic             snap_lines,
	output logic [6:0]       text_pos,
	output logic [6:0]       box_size,
	output logic [1:0]       align_mode
);

	item_t   item_in;
	item_t   item_s1;
	logic    fire;
	logic    out_free;
	logic    res_valid;
	result_t res_data;
	result_t result_q;

	assign item_in = '{char_code: char_code, no_char: no_char, string_end: string_end};

	csp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.item_in    (item_in),
		.out_free   (out_free),
		.item_s1    (item_s1),
		.fire       (fire)
	);

	csp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	csp_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res_data     (res_data),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_q     (result_q)
	);

	assign writing_dir = result_q.writing_dir;
	assign line_pos    = result_q.line_pos;
	assign snap_lines  = result_q.snap_lines;
	assign text_pos    = result_q.text_pos;
	assign box_size    = result_q.box_size;
	assign align_mode  = result_q.align_mode;

endmodule

`default_nettype wire
